### src/rcp_pkg.sv
`timescale 1ns / 1ps

package rcp_pkg;

   // pool geometry
   localparam int POOL_CHUNKS = 256;
   localparam int IDX_W       = (POOL_CHUNKS > 1) ? $clog2(POOL_CHUNKS) : 1;
   localparam int CNT_W       = $clog2(POOL_CHUNKS + 1);

   // free search works on groups of chunks: first a non-full group, then a chunk in it
   localparam int GROUP_SIZE = 16;
   localparam int GROUP_NUM  = (POOL_CHUNKS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GRP_W      = (GROUP_NUM > 1) ? $clog2(GROUP_NUM) : 1;
   localparam int SUB_W      = $clog2(GROUP_SIZE);
   localparam int PAD_W      = GROUP_NUM * GROUP_SIZE;

   // field widths of the ports
   localparam int OP_W     = 3;
   localparam int ID_W     = 16;
   localparam int REF_W    = 16;
   localparam int RID_W    = 8;
   localparam int TOTAL_W  = 9;
   localparam int ROUTE_W  = 2;
   localparam int CSR_W    = 9;
   localparam int CSR_IX_W = 1;

   localparam logic [REF_W-1:0] REF_MAX = '1;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [GRP_W-1:0]   grp_type;
   typedef logic [SUB_W-1:0]   sub_type;
   typedef logic [REF_W-1:0]   ref_type;
   typedef logic [RID_W-1:0]   rid_type;
   typedef logic [TOTAL_W-1:0] total_type;
   typedef logic [ROUTE_W-1:0] route_type;
   typedef logic [CSR_W-1:0]   csr_data_type;

   // configuration register indexes
   localparam logic [CSR_IX_W-1:0] CSR_SEAL_ROUTE = 1'd0;
   localparam logic [CSR_IX_W-1:0] CSR_RESERVE    = 1'd1;

   // seal routes
   localparam route_type ROUTE_ADMIT  = 2'd0;
   localparam route_type ROUTE_LOADED = 2'd1;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC    = 3'd0,
      OP_RETAIN   = 3'd1,
      OP_RELEASE  = 3'd2,
      OP_TRY_FREE = 3'd3,
      OP_REL_FREE = 3'd4,
      OP_SEAL     = 3'd5,
      OP_QUERY    = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      STAT_DONE      = 3'd0,
      STAT_NOT_MET   = 3'd1,
      STAT_RANGE     = 3'd2,
      STAT_EXHAUSTED = 3'd3,
      STAT_SATURATED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      LIFE_FREE   = 2'd0,
      LIFE_REC    = 2'd1,
      LIFE_SEALED = 2'd2
   } life_type;

   typedef enum logic [1:0] {
      NOTE_NONE      = 2'd0,
      NOTE_ADMIT     = 2'd1,
      NOTE_PERSISTED = 2'd2,
      NOTE_FREED     = 2'd3
   } notice_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FIND,
      S_EXEC
   } state_type;

   // one table entry in the memory
   typedef struct packed {
      life_type life;
      ref_type  refc;
   } entry_type;

endpackage

### src/refcounted_chunk_pool_top.sv
`timescale 1ns / 1ps

// Reference-counted chunk pool.
// Request channel (req_valid/req_stall): op and chunk_id. Allocate takes the
// lowest unused chunk; retain, release, try-free, release-then-free, seal and
// query work on the chunk named by chunk_id.
// Response channel (rsp_valid/rsp_stall): one result per request, carrying
// status, the chunk's entry after the op, a notice code, the used and free
// totals and the reserve check.
// Config port (csr_we/csr_index/csr_wdata): seal route and reserve count. The
// user must write them only while no request is in flight; it is not enforced.
// A request goes from idle to the execute step, passing through the find
// step first for allocate; its result is loaded into the output register
// when the execute step finishes. One request is in flight at a time, so
// a new request is taken only after the last one leaves the execute step.
// The steps are set by the read-modify-write of the entry memory and, for
// allocate, by the two-step free search (group, then chunk in group).
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls and the register is still full, the
// next result holds in the execute step until the register frees up.
// Reset clears the used bitmap, the entry valid bits, the used count and the
// config registers directly; there is no clearing pass.

module refcounted_chunk_pool_top (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rcp_pkg::OP_W-1:0]     req_op,
   input  logic [rcp_pkg::ID_W-1:0]     req_chunk_id,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic [rcp_pkg::RID_W-1:0]    rsp_result_id,
   output logic [1:0]                   rsp_life_state,
   output logic [rcp_pkg::REF_W-1:0]    rsp_ref_count,
   output logic                         rsp_in_use,
   output logic [1:0]                   rsp_notice,
   output logic [rcp_pkg::TOTAL_W-1:0]  rsp_used_total,
   output logic [rcp_pkg::TOTAL_W-1:0]  rsp_free_total,
   output logic                         rsp_reserve_ok,
   // config port
   input  logic                         csr_we,
   input  logic [rcp_pkg::CSR_IX_W-1:0] csr_index,
   input  logic [rcp_pkg::CSR_W-1:0]    csr_wdata
);

   // control state
   rcp_pkg::state_type state_ff, state_in;
   logic [rcp_pkg::POOL_CHUNKS-1:0] used_ff;
   logic [rcp_pkg::POOL_CHUNKS-1:0] entry_vld_ff;
   rcp_pkg::cnt_type   used_count_ff, used_count_in;
   rcp_pkg::route_type seal_route_ff;
   rcp_pkg::csr_data_type reserve_ff;

   // request held during the op
   rcp_pkg::op_type  op_ff;
   rcp_pkg::idx_type idx_ff, idx_in;
   rcp_pkg::rid_type rid_ff;
   logic             range_ff;
   logic             exh_ff, exh_in;
   rcp_pkg::grp_type grp_ff;
   logic             grp_found_ff;

   // entry memory
   rcp_pkg::entry_type entry_mem_ff [rcp_pkg::POOL_CHUNKS];
   rcp_pkg::entry_type rd_data_ff;
   logic               rd_en;
   rcp_pkg::idx_type   rd_addr;
   logic               wr_en;
   rcp_pkg::entry_type wr_data;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   rcp_pkg::status_type    rsp_status_ff, rsp_status_in;
   rcp_pkg::rid_type       rsp_rid_ff, rsp_rid_in;
   rcp_pkg::life_type      rsp_life_ff, rsp_life_in;
   rcp_pkg::ref_type       rsp_ref_ff, rsp_ref_in;
   logic                   rsp_use_ff, rsp_use_in;
   rcp_pkg::notice_type    rsp_notice_ff, rsp_notice_in;
   rcp_pkg::total_type     rsp_used_ff, rsp_used_in;
   rcp_pkg::total_type     rsp_free_ff, rsp_free_in;
   logic                   rsp_rok_ff, rsp_rok_in;

   // handshake
   logic req_xfer;
   logic exec_done;

   // free search
   logic [rcp_pkg::PAD_W-1:0]      bitmap_pad;
   logic [rcp_pkg::GROUP_NUM-1:0]  grp_full;
   rcp_pkg::grp_type               grp_sel;
   logic                           grp_any;
   logic [rcp_pkg::GROUP_SIZE-1:0] grp_bits;
   rcp_pkg::sub_type               sub_sel;
   logic                           sub_any;

   // execute datapath
   logic                   cur_used;
   rcp_pkg::life_type      cur_life;
   rcp_pkg::ref_type       cur_ref;
   rcp_pkg::ref_type       rel_ref;
   logic                   new_used;
   rcp_pkg::life_type      new_life;
   rcp_pkg::ref_type       new_ref;
   rcp_pkg::status_type    status_c;
   rcp_pkg::notice_type    notice_c;
   rcp_pkg::cnt_type       free_c;

   assign req_stall = (state_ff != rcp_pkg::S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign exec_done = (state_ff == rcp_pkg::S_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // used bitmap padded with ones past the pool end
   always_comb begin
      bitmap_pad = '1;
      for (int i = 0; i < rcp_pkg::POOL_CHUNKS; i++) begin
         bitmap_pad[i] = used_ff[i];
      end
   end

   // lowest group with a free chunk
   always_comb begin
      grp_sel = '0;
      grp_any = 1'b0;
      for (int g = rcp_pkg::GROUP_NUM - 1; g >= 0; g--) begin
         grp_full[g] = &bitmap_pad[g*rcp_pkg::GROUP_SIZE +: rcp_pkg::GROUP_SIZE];
         if (!grp_full[g]) begin
            grp_any = 1'b1;
            grp_sel = rcp_pkg::grp_type'(g);
         end
      end
   end

   // lowest free chunk inside the chosen group
   always_comb begin
      grp_bits = bitmap_pad[grp_ff*rcp_pkg::GROUP_SIZE +: rcp_pkg::GROUP_SIZE];
      sub_sel  = '0;
      sub_any  = 1'b0;
      for (int b = rcp_pkg::GROUP_SIZE - 1; b >= 0; b--) begin
         if (!grp_bits[b]) begin
            sub_any = 1'b1;
            sub_sel = rcp_pkg::sub_type'(b);
         end
      end
   end

   // state machine and memory read control
   always_comb begin
      state_in = state_ff;
      rd_en    = 1'b0;
      rd_addr  = rcp_pkg::idx_type'(req_chunk_id);
      idx_in   = idx_ff;
      exh_in   = exh_ff;
      case (state_ff)
         rcp_pkg::S_IDLE: begin
            idx_in = rcp_pkg::idx_type'(req_chunk_id);
            exh_in = 1'b0;
            if (req_xfer) begin
               if (rcp_pkg::op_type'(req_op) == rcp_pkg::OP_ALLOC) begin
                  state_in = rcp_pkg::S_FIND;
               end else begin
                  rd_en    = (32'(req_chunk_id) < rcp_pkg::POOL_CHUNKS);
                  state_in = rcp_pkg::S_EXEC;
               end
            end
         end
         rcp_pkg::S_FIND: begin
            idx_in   = rcp_pkg::idx_type'({grp_ff, sub_sel});
            exh_in   = !(grp_found_ff && sub_any);
            rd_addr  = idx_in;
            rd_en    = !exh_in;
            state_in = rcp_pkg::S_EXEC;
         end
         rcp_pkg::S_EXEC: begin
            if (exec_done) begin
               state_in = rcp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rcp_pkg::S_IDLE;
         end
      endcase
   end

   // execute: modify the entry read from memory
   always_comb begin
      cur_used = used_ff[idx_ff];
      cur_life = entry_vld_ff[idx_ff] ? rd_data_ff.life : rcp_pkg::LIFE_FREE;
      cur_ref  = entry_vld_ff[idx_ff] ? rd_data_ff.refc : '0;
      rel_ref  = (op_ff == rcp_pkg::OP_REL_FREE && cur_ref != '0) ?
                 cur_ref - rcp_pkg::ref_type'(1) : cur_ref;
      new_used = cur_used;
      new_life = cur_life;
      new_ref  = cur_ref;
      status_c = rcp_pkg::STAT_DONE;
      notice_c = rcp_pkg::NOTE_NONE;
      used_count_in = used_count_ff;
      case (op_ff)
         rcp_pkg::OP_ALLOC: begin
            new_used = 1'b1;
            new_life = rcp_pkg::LIFE_REC;
            used_count_in = used_count_ff + rcp_pkg::cnt_type'(1);
         end
         rcp_pkg::OP_RETAIN: begin
            if (cur_ref == rcp_pkg::REF_MAX) begin
               status_c = rcp_pkg::STAT_SATURATED;
            end else begin
               new_ref = cur_ref + rcp_pkg::ref_type'(1);
            end
         end
         rcp_pkg::OP_RELEASE: begin
            if (cur_ref == '0) begin
               status_c = rcp_pkg::STAT_NOT_MET;
            end else begin
               new_ref = cur_ref - rcp_pkg::ref_type'(1);
            end
         end
         rcp_pkg::OP_TRY_FREE, rcp_pkg::OP_REL_FREE: begin
            new_ref = rel_ref;
            if (rel_ref != '0) begin
               status_c = rcp_pkg::STAT_NOT_MET;
            end else begin
               new_used = 1'b0;
               new_life = rcp_pkg::LIFE_FREE;
               notice_c = rcp_pkg::NOTE_FREED;
               if (cur_used && used_count_ff != '0) begin
                  used_count_in = used_count_ff - rcp_pkg::cnt_type'(1);
               end
            end
         end
         rcp_pkg::OP_SEAL: begin
            if (cur_life != rcp_pkg::LIFE_REC) begin
               status_c = rcp_pkg::STAT_NOT_MET;
            end else begin
               new_life = rcp_pkg::LIFE_SEALED;
               case (seal_route_ff)
                  rcp_pkg::ROUTE_ADMIT:  notice_c = rcp_pkg::NOTE_ADMIT;
                  rcp_pkg::ROUTE_LOADED: notice_c = rcp_pkg::NOTE_PERSISTED;
                  default:               notice_c = rcp_pkg::NOTE_NONE;
               endcase
            end
         end
         default: begin
         end
      endcase

      // out-of-range and exhausted requests leave the state alone
      wr_en = exec_done && !range_ff && !exh_ff;
      if (range_ff || exh_ff) begin
         used_count_in = used_count_ff;
      end
      wr_data.life = new_life;
      wr_data.refc = new_ref;

      free_c = rcp_pkg::cnt_type'(rcp_pkg::POOL_CHUNKS) - used_count_in;

      // response fields
      rsp_status_in = status_c;
      rsp_rid_in    = (op_ff == rcp_pkg::OP_ALLOC) ? rcp_pkg::rid_type'(idx_ff) : rid_ff;
      rsp_life_in   = new_life;
      rsp_ref_in    = new_ref;
      rsp_use_in    = new_used;
      rsp_notice_in = notice_c;
      if (range_ff) begin
         rsp_status_in = rcp_pkg::STAT_RANGE;
         rsp_rid_in    = rid_ff;
      end else if (exh_ff) begin
         rsp_status_in = rcp_pkg::STAT_EXHAUSTED;
         rsp_rid_in    = '0;
      end
      if (range_ff || exh_ff) begin
         rsp_life_in   = rcp_pkg::LIFE_FREE;
         rsp_ref_in    = '0;
         rsp_use_in    = 1'b0;
         rsp_notice_in = rcp_pkg::NOTE_NONE;
      end
      rsp_used_in = rcp_pkg::total_type'(used_count_in);
      rsp_free_in = rcp_pkg::total_type'(free_c);
      rsp_rok_in  = (rcp_pkg::total_type'(free_c) > rcp_pkg::total_type'(reserve_ff));

      // response register occupancy
      rsp_valid_in = rsp_valid_ff;
      if (exec_done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rcp_pkg::S_IDLE;
         used_ff       <= '0;
         entry_vld_ff  <= '0;
         used_count_ff <= '0;
         seal_route_ff <= '0;
         reserve_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_done) begin
            used_count_ff <= used_count_in;
         end
         if (wr_en) begin
            used_ff[idx_ff]      <= new_used;
            entry_vld_ff[idx_ff] <= 1'b1;
         end
         // config writes
         if (csr_we) begin
            case (csr_index)
               rcp_pkg::CSR_SEAL_ROUTE: seal_route_ff <= rcp_pkg::route_type'(csr_wdata);
               rcp_pkg::CSR_RESERVE:    reserve_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // request capture and search registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      exh_ff <= exh_in;
      if (req_xfer) begin
         op_ff        <= rcp_pkg::op_type'(req_op);
         rid_ff       <= rcp_pkg::rid_type'(req_chunk_id);
         range_ff     <= (rcp_pkg::op_type'(req_op) != rcp_pkg::OP_ALLOC) &&
                         (32'(req_chunk_id) >= rcp_pkg::POOL_CHUNKS);
         grp_ff       <= grp_sel;
         grp_found_ff <= grp_any;
      end
   end

   // entry memory: one read, one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[idx_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (exec_done) begin
         rsp_status_ff <= rsp_status_in;
         rsp_rid_ff    <= rsp_rid_in;
         rsp_life_ff   <= rsp_life_in;
         rsp_ref_ff    <= rsp_ref_in;
         rsp_use_ff    <= rsp_use_in;
         rsp_notice_ff <= rsp_notice_in;
         rsp_used_ff   <= rsp_used_in;
         rsp_free_ff   <= rsp_free_in;
         rsp_rok_ff    <= rsp_rok_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_result_id  = rsp_rid_ff;
   assign rsp_life_state = rsp_life_ff;
   assign rsp_ref_count  = rsp_ref_ff;
   assign rsp_in_use     = rsp_use_ff;
   assign rsp_notice     = rsp_notice_ff;
   assign rsp_used_total = rsp_used_ff;
   assign rsp_free_total = rsp_free_ff;
   assign rsp_reserve_ok = rsp_rok_ff;

   // used count tracks the bitmap
   a_used_count: assert property (@(posedge clock) disable iff (reset)
      32'(used_count_ff) == $countones(used_ff))
      else $error("used count differs from used bitmap");

   // a new result only comes out of the execute step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == rcp_pkg::S_EXEC))
      else $error("response loaded outside execute step");

   // totals in a valid response always add up to the pool size
   a_totals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (32'(rsp_used_ff) + 32'(rsp_free_ff) == rcp_pkg::POOL_CHUNKS))
      else $error("used and free totals do not add up");

   // a group picked as non-full still has a free chunk when searched
   a_group_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rcp_pkg::S_FIND && grp_found_ff) |-> sub_any)
      else $error("chosen group has no free chunk");

endmodule

### sim/tb_refcounted_chunk_pool_top.sv
`timescale 1ns / 1ps

module tb_refcounted_chunk_pool_top;

   // op code 7 has no name in the package and acts as a query
   localparam logic [rcp_pkg::OP_W-1:0] OP_QUERY_ALT    = 3'd7;
   // seal routes without a package name
   localparam rcp_pkg::route_type       ROUTE_EPHEMERAL = 2'd2;
   localparam rcp_pkg::route_type       ROUTE_SPARE     = 2'd3;
   localparam int                       LIMIT_CYCLES    = 1_500_000;
   // receiver stall patterns
   localparam int                       STALL_NONE      = 0;
   localparam int                       STALL_SOME      = 1;
   localparam int                       STALL_HEAVY     = 2;

   typedef struct {
      logic                         drain;
      logic [rcp_pkg::OP_W-1:0]     op;
      logic [rcp_pkg::ID_W-1:0]     chunk_id;
   } op_item_type;

   typedef struct {
      rcp_pkg::status_type status;
      rcp_pkg::rid_type    rid;
      rcp_pkg::life_type   life;
      rcp_pkg::ref_type    refc;
      logic                in_use;
      rcp_pkg::notice_type notice;
      rcp_pkg::total_type  used_total;
      rcp_pkg::total_type  free_total;
      logic                reserve_ok;
   } pool_outcome_type;

   logic                         clock        = 1'b0;
   logic                         reset        = 1'b1;
   logic                         req_valid    = 1'b0;
   logic                         req_stall;
   logic [rcp_pkg::OP_W-1:0]     req_op       = '0;
   logic [rcp_pkg::ID_W-1:0]     req_chunk_id = '0;
   logic                         rsp_valid;
   logic                         rsp_stall    = 1'b0;
   logic [2:0]                   rsp_status;
   logic [rcp_pkg::RID_W-1:0]    rsp_result_id;
   logic [1:0]                   rsp_life_state;
   logic [rcp_pkg::REF_W-1:0]    rsp_ref_count;
   logic                         rsp_in_use;
   logic [1:0]                   rsp_notice;
   logic [rcp_pkg::TOTAL_W-1:0]  rsp_used_total;
   logic [rcp_pkg::TOTAL_W-1:0]  rsp_free_total;
   logic                         rsp_reserve_ok;
   logic                         csr_we       = 1'b0;
   logic [rcp_pkg::CSR_IX_W-1:0] csr_index    = '0;
   rcp_pkg::csr_data_type        csr_wdata    = '0;

   // shadow copy of the pool and its registers
   logic               chunk_used [rcp_pkg::POOL_CHUNKS];
   rcp_pkg::life_type  chunk_life [rcp_pkg::POOL_CHUNKS];
   rcp_pkg::ref_type   chunk_refs [rcp_pkg::POOL_CHUNKS];
   int                 pool_used;
   rcp_pkg::route_type seal_route_cfg;
   int                 reserve_cfg;

   op_item_type      op_backlog[$];
   pool_outcome_type pool_outcomes[$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int ops_queued     = 0;
   bit quiet          = 1'b0;
   int burst_left;
   int gap_left;
   int stall_mode;
   int stall_left;

   refcounted_chunk_pool_top u_top (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // shadow pool: apply one request, return the result it must produce
   function automatic pool_outcome_type pool_apply(input logic [rcp_pkg::OP_W-1:0] op,
                                                   input logic [rcp_pkg::ID_W-1:0] id);
      pool_outcome_type o;
      int               k;
      int               slot;
      int               free_chunks;
      o.status = rcp_pkg::STAT_DONE;
      o.rid    = id[rcp_pkg::RID_W-1:0];
      o.life   = rcp_pkg::LIFE_FREE;
      o.refc   = '0;
      o.in_use = 1'b0;
      o.notice = rcp_pkg::NOTE_NONE;
      if (op == rcp_pkg::OP_ALLOC) begin
         // lowest unused chunk; its count is left as it was
         slot = -1;
         for (k = 0; k < rcp_pkg::POOL_CHUNKS; k++)
            if (!chunk_used[k] && slot < 0) slot = k;
         if (slot >= 0) begin
            chunk_used[slot] = 1'b1;
            chunk_life[slot] = rcp_pkg::LIFE_REC;
            pool_used++;
            o.rid    = slot[rcp_pkg::RID_W-1:0];
            o.life   = rcp_pkg::LIFE_REC;
            o.refc   = chunk_refs[slot];
            o.in_use = 1'b1;
         end else begin
            o.status = rcp_pkg::STAT_EXHAUSTED;
            o.rid    = '0;
         end
      end else if (id >= rcp_pkg::POOL_CHUNKS) begin
         o.status = rcp_pkg::STAT_RANGE;
      end else begin
         k = id;
         case (op)
            rcp_pkg::OP_RETAIN: begin
               if (chunk_refs[k] == rcp_pkg::REF_MAX) o.status = rcp_pkg::STAT_SATURATED;
               else chunk_refs[k]++;
            end
            rcp_pkg::OP_RELEASE: begin
               if (chunk_refs[k] == 0) o.status = rcp_pkg::STAT_NOT_MET;
               else chunk_refs[k]--;
            end
            rcp_pkg::OP_TRY_FREE, rcp_pkg::OP_REL_FREE: begin
               if (op == rcp_pkg::OP_REL_FREE && chunk_refs[k] != 0) chunk_refs[k]--;
               if (chunk_refs[k] != 0) begin
                  o.status = rcp_pkg::STAT_NOT_MET;
               end else begin
                  // freeing an unused chunk still reports, count only drops if used
                  if (chunk_used[k] && pool_used > 0) pool_used--;
                  chunk_used[k] = 1'b0;
                  chunk_life[k] = rcp_pkg::LIFE_FREE;
                  o.notice      = rcp_pkg::NOTE_FREED;
               end
            end
            rcp_pkg::OP_SEAL: begin
               if (chunk_life[k] != rcp_pkg::LIFE_REC) begin
                  o.status = rcp_pkg::STAT_NOT_MET;
               end else begin
                  chunk_life[k] = rcp_pkg::LIFE_SEALED;
                  case (seal_route_cfg)
                     rcp_pkg::ROUTE_ADMIT:  o.notice = rcp_pkg::NOTE_ADMIT;
                     rcp_pkg::ROUTE_LOADED: o.notice = rcp_pkg::NOTE_PERSISTED;
                     default:               o.notice = rcp_pkg::NOTE_NONE;
                  endcase
               end
            end
            default: ;
         endcase
         o.life   = chunk_life[k];
         o.refc   = chunk_refs[k];
         o.in_use = chunk_used[k];
      end
      free_chunks  = rcp_pkg::POOL_CHUNKS - pool_used;
      o.used_total = pool_used[rcp_pkg::TOTAL_W-1:0];
      o.free_total = free_chunks[rcp_pkg::TOTAL_W-1:0];
      o.reserve_ok = (free_chunks > reserve_cfg);
      return o;
   endfunction

   task automatic queue_op(input logic [rcp_pkg::OP_W-1:0] op, input int id);
      op_item_type it;
      it.drain    = 1'b0;
      it.op       = op;
      it.chunk_id = id[rcp_pkg::ID_W-1:0];
      op_backlog.insert(op_backlog.size(), it);
      ops_queued++;
   endtask

   // random traffic: mostly well-formed chunk lifetimes, some noise
   task automatic queue_random_ops(input int target, input int alloc_pct, input int free_pct,
                                   input bit until_full);
      int          start;
      int          roll;
      int          k;
      int          n;
      int          hi;
      bit          paused;
      op_item_type pause;
      start          = ops_queued;
      paused         = 1'b0;
      pause.drain    = 1'b1;
      pause.op       = rcp_pkg::OP_QUERY;
      pause.chunk_id = '0;
      while (ops_queued - start < target ||
             (until_full && pool_used < rcp_pkg::POOL_CHUNKS &&
              ops_queued - start < 4 * target)) begin
         while (op_backlog.size() > 2) @(posedge clock);
         if (!paused && ops_queued - start >= target / 2) begin
            op_backlog.insert(op_backlog.size(), pause);
            paused = 1'b1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            // noise: any op code, any id
            n = $urandom_range(1, 3);
            repeat (n)
               queue_op(rcp_pkg::OP_W'($urandom_range(0, 7)), ($urandom_range(0, 3) == 0) ?
                        $urandom_range(0, 65535) : $urandom_range(0, rcp_pkg::POOL_CHUNKS - 1));
         end else if (roll < 10 + alloc_pct * 9 / 10) begin
            if (until_full && $urandom_range(0, 1) == 0) begin
               repeat ($urandom_range(2, 8))
                  queue_op(rcp_pkg::OP_ALLOC, $urandom_range(0, 65535));
            end else begin
               // allocate, then a short life of the chunk it should get
               k = 0;
               while (k < rcp_pkg::POOL_CHUNKS - 1 && chunk_used[k]) k++;
               n = $urandom_range(0, 3);
               queue_op(rcp_pkg::OP_ALLOC, $urandom_range(0, 65535));
               repeat (n) queue_op(rcp_pkg::OP_RETAIN, k);
               if ($urandom_range(0, 4) != 0) queue_op(rcp_pkg::OP_SEAL, k);
               if ($urandom_range(0, 2) == 0) queue_op(rcp_pkg::OP_QUERY, k);
               if ($urandom_range(0, 99) < free_pct) begin
                  repeat ((n > 0) ? n - 1 : 0) queue_op(rcp_pkg::OP_RELEASE, k);
                  queue_op((n > 0) ? rcp_pkg::OP_REL_FREE : rcp_pkg::OP_TRY_FREE, k);
               end
            end
         end else begin
            // work on a chunk that is likely in use
            hi = (pool_used + 8 < rcp_pkg::POOL_CHUNKS) ? pool_used + 8 :
                 rcp_pkg::POOL_CHUNKS - 1;
            k  = $urandom_range(0, rcp_pkg::POOL_CHUNKS - 1);
            for (n = 0; n < 16 && !chunk_used[k]; n++) k = $urandom_range(0, hi);
            if ($urandom_range(0, 99) < free_pct) begin
               n = (chunk_refs[k] < 4) ? chunk_refs[k] : 4;
               repeat ((n > 0) ? n - 1 : 0) queue_op(rcp_pkg::OP_RELEASE, k);
               queue_op(($urandom_range(0, 2) == 0) ? rcp_pkg::OP_TRY_FREE :
                        rcp_pkg::OP_REL_FREE, k);
            end else begin
               repeat ($urandom_range(2, 5))
                  queue_op(rcp_pkg::OP_W'($urandom_range(rcp_pkg::OP_RETAIN,
                                                         rcp_pkg::OP_QUERY)), k);
            end
         end
      end
   endtask

   task automatic wait_pool_idle();
      while (op_backlog.size() != 0 || req_valid || pool_outcomes.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(input logic [rcp_pkg::CSR_IX_W-1:0] index, input int value);
      rcp_pkg::csr_data_type data;
      data = value[rcp_pkg::CSR_W-1:0];
      if (index == rcp_pkg::CSR_SEAL_ROUTE) begin
         // bits above the route field are don't-care
         data = rcp_pkg::csr_data_type'($urandom_range(0, 511));
         data[rcp_pkg::ROUTE_W-1:0] = value[rcp_pkg::ROUTE_W-1:0];
         seal_route_cfg = value[rcp_pkg::ROUTE_W-1:0];
      end else begin
         reserve_cfg = value & 511;
      end
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
      end
   endtask

   // request driver: bursts with random gaps, pause markers wait for drain
   always @(posedge clock) begin : drive_requests
      op_item_type next_item;
      logic        next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         // a transfer commits the request to the shadow pool
         if (req_valid && !req_stall)
            pool_outcomes.insert(pool_outcomes.size(), pool_apply(req_op, req_chunk_id));
         if (!req_valid || !req_stall) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (op_backlog.size() != 0) begin
               if (op_backlog[0].drain) begin
                  if (pool_outcomes.size() == 0) op_backlog.delete(0);
               end else begin
                  next_item  = op_backlog.pop_front();
                  next_valid = 1'b1;
                  if (burst_left > 1) begin
                     burst_left--;
                  end else begin
                     burst_left = $urandom_range(1, 24);
                     if (quiet || $urandom_range(0, 3) == 0) gap_left = 0;
                     else if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(9, 16);
                     else gap_left = $urandom_range(1, 5);
                  end
               end
            end
            req_valid <= next_valid;
            if (next_valid) begin
               req_op       <= next_item.op;
               req_chunk_id <= next_item.chunk_id;
            end
         end
      end
   end

   // result monitor and receiver stall pattern
   always @(posedge clock) begin : watch_results
      pool_outcome_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode = STALL_NONE;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pool_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result transfer with nothing expected", $time);
            end else begin
               want = pool_outcomes.pop_front();
               check_field("status", rsp_status, want.status);
               check_field("result_id", rsp_result_id, want.rid);
               check_field("life_state", rsp_life_state, want.life);
               check_field("ref_count", rsp_ref_count, want.refc);
               check_field("in_use", rsp_in_use, want.in_use);
               check_field("notice", rsp_notice, want.notice);
               check_field("used_total", rsp_used_total, want.used_total);
               check_field("free_total", rsp_free_total, want.free_total);
               check_field("reserve_ok", rsp_reserve_ok, want.reserve_ok);
            end
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
            stall_left = $urandom_range(20, 200);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            STALL_SOME:  rsp_stall <= !quiet && ($urandom_range(0, 2) == 0);
            STALL_HEAVY: rsp_stall <= !quiet && ($urandom_range(0, 9) < 7);
            default:     rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAIL refcounted_chunk_pool_top");
         $finish;
      end
   end

   initial begin
      int i;
      int n;
      for (i = 0; i < rcp_pkg::POOL_CHUNKS; i++) begin
         chunk_used[i] = 1'b0;
         chunk_life[i] = rcp_pkg::LIFE_FREE;
         chunk_refs[i] = '0;
      end
      pool_used      = 0;
      seal_route_cfg = rcp_pkg::ROUTE_ADMIT;
      reserve_cfg    = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset defaults, range errors, each op and its corner cases
      queue_op(rcp_pkg::OP_QUERY, 0);
      queue_op(OP_QUERY_ALT, 5);
      queue_op(rcp_pkg::OP_RETAIN, rcp_pkg::POOL_CHUNKS);
      queue_op(rcp_pkg::OP_SEAL, 16'hFFFF);
      queue_op(rcp_pkg::OP_RELEASE, 16'h8000);
      queue_op(rcp_pkg::OP_TRY_FREE, 16'h7F00);
      queue_op(rcp_pkg::OP_RELEASE, 3);
      queue_op(rcp_pkg::OP_TRY_FREE, 200);
      queue_op(rcp_pkg::OP_ALLOC, 16'hFFFF);
      queue_op(rcp_pkg::OP_RETAIN, 0);
      queue_op(rcp_pkg::OP_RETAIN, 0);
      queue_op(rcp_pkg::OP_SEAL, 0);
      queue_op(rcp_pkg::OP_SEAL, 0);
      queue_op(rcp_pkg::OP_TRY_FREE, 0);
      queue_op(rcp_pkg::OP_RELEASE, 0);
      queue_op(rcp_pkg::OP_REL_FREE, 0);
      queue_op(rcp_pkg::OP_REL_FREE, 0);
      queue_op(rcp_pkg::OP_ALLOC, 0);
      queue_op(rcp_pkg::OP_ALLOC, 0);
      queue_op(rcp_pkg::OP_RETAIN, 1);
      queue_op(rcp_pkg::OP_REL_FREE, 1);
      queue_op(rcp_pkg::OP_SEAL, 1);
      queue_op(rcp_pkg::OP_QUERY, 1);
      queue_op(rcp_pkg::OP_QUERY, 255);
      queue_op(rcp_pkg::OP_ALLOC, 0);
      wait_pool_idle();

      // mixed traffic with a reserve equal to the pool size
      write_csr(rcp_pkg::CSR_SEAL_ROUTE, rcp_pkg::ROUTE_LOADED);
      write_csr(rcp_pkg::CSR_RESERVE, 256);
      queue_random_ops(150, 40, 30, 1'b0);
      wait_pool_idle();

      // fill the pool, then run it dry
      write_csr(rcp_pkg::CSR_SEAL_ROUTE, ROUTE_EPHEMERAL);
      write_csr(rcp_pkg::CSR_RESERVE, 255);
      queue_random_ops(150, 80, 5, 1'b1);
      wait_pool_idle();
      n = rcp_pkg::POOL_CHUNKS - pool_used + 3;
      repeat (n) queue_op(rcp_pkg::OP_ALLOC, $urandom_range(0, 65535));
      wait_pool_idle();

      // mostly frees, reserve beyond the pool size
      write_csr(rcp_pkg::CSR_SEAL_ROUTE, ROUTE_SPARE);
      write_csr(rcp_pkg::CSR_RESERVE, 511);
      queue_random_ops(150, 5, 85, 1'b0);
      wait_pool_idle();

      // back-to-back traffic on the top chunk with no receiver stalls
      quiet = 1'b1;
      write_csr(rcp_pkg::CSR_SEAL_ROUTE, rcp_pkg::ROUTE_ADMIT);
      write_csr(rcp_pkg::CSR_RESERVE, 0);
      repeat (4) queue_op(rcp_pkg::OP_RETAIN, rcp_pkg::POOL_CHUNKS - 1);
      queue_op(rcp_pkg::OP_TRY_FREE, rcp_pkg::POOL_CHUNKS - 1);
      queue_op(rcp_pkg::OP_RELEASE, rcp_pkg::POOL_CHUNKS - 1);
      queue_op(rcp_pkg::OP_REL_FREE, rcp_pkg::POOL_CHUNKS - 1);
      queue_op(rcp_pkg::OP_REL_FREE, rcp_pkg::POOL_CHUNKS - 1);
      queue_op(rcp_pkg::OP_QUERY, rcp_pkg::POOL_CHUNKS - 1);
      wait_pool_idle();
      quiet = 1'b0;

      // closing mix at a middle reserve
      write_csr(rcp_pkg::CSR_RESERVE, 128);
      write_csr(rcp_pkg::CSR_SEAL_ROUTE, rcp_pkg::ROUTE_LOADED);
      queue_random_ops(130, 40, 40, 1'b0);
      wait_pool_idle();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pool_outcomes.size() == 0)
         $display("PASS refcounted_chunk_pool_top");
      else
         $display("FAIL refcounted_chunk_pool_top");
      $finish;
   end

endmodule
